/* sv/gaussian_window_filter_macros.svh */
// Assertion macros for the Gaussian window filter.
`ifndef GAUSSIAN_WINDOW_FILTER_MACROS_SVH
`define GAUSSIAN_WINDOW_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define GWF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gwf assertion failed");
`define GWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gwf implication failed");
`define GWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gwf next-cycle check failed");
`else
`define GWF_ASSERT(lbl, clk, rst_n, prop)
`define GWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/gwf_pkg.sv */
// Shared constants, register codes and coefficient helper for the Gaussian window filter.
package gwf_pkg;

  localparam int PIX_W      = 8;
  localparam int KSEL_W     = 2;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [KSEL_W-1:0]  KSEL_RST   = 2'd0;
  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_KSEL   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Normalized 1-D Gaussian weights, Q0.32, per kernel size (3, 5, 7).
  localparam logic [31:0] WEIGHT_1D [3][4] = '{
    '{32'd1650974012, 32'd1321996642, 32'd0,         32'd0},
    '{32'd1254481428, 32'd1004510201, 32'd515732734, 32'd0},
    '{32'd1162570980, 32'd930914067,  32'd477947218, 32'd157336873}
  };

  // 2-D coefficient in Q0.frac, rounded half up; elaboration use only.
  function automatic logic [31:0] coef_calc(int t, int a, int b, int frac);
    longint unsigned p;
    p = longint'(WEIGHT_1D[t][a]) * longint'(WEIGHT_1D[t][b]);
    p = (p + (64'd1 << (63 - frac))) >> (64 - frac);
    return p[31:0];
  endfunction

endpackage

/* sv/gaussian_window_filter.sv */
// Gaussian window filter top level: line store, window, MAC pipeline and APB registers.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | sink      | in_valid_i/in_ready_o | pixel_i
//  out     | source    | out_valid_o/out_ready_i | value_o, out_row_o, out_col_o, last_of_frame_o
//  cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One pixel per clock sustained while out_ready_i does not stall the pipeline.
// The line store is one read-modify-write memory with one column of rows per word;
// back-to-back requests to the same column are served by forwarding the last write.
// Each stage loads when empty or when the stage after it moves, so bubbles collapse.
// Reset clears counters, window and valid bits; the line store needs no clearing.
`include "gaussian_window_filter_macros.svh"

module gaussian_window_filter import gwf_pkg::*; #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_KERNEL     = 7,
  parameter int COEF_FRAC_BITS = 16,
  localparam int CW            = $clog2(MAX_WIDTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIX_W-1:0]    value_o,
  output logic [ROW_W-1:0]    out_row_o,
  output logic [CW-1:0]       out_col_o,
  output logic                last_of_frame_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int M     = MAX_KERNEL;
  localparam int KMAX  = ((M - 1) / 2) * 2 + 1;
  localparam int LW    = (M - 1) * PIX_W;
  localparam int CMPW  = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int CFW   = COEF_FRAC_BITS + 1;
  localparam int PW    = PIX_W + CFW;
  localparam int RSW   = PW + $clog2(M);
  localparam int TSW   = RSW + $clog2(M);
  localparam int KW    = 4;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [CW-1:0]    col;
    logic             last;
  } meta_t;

  // ---------------- configuration ----------------
  logic [KSEL_W-1:0]  ksel_q;
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= KSEL_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KSEL:   ksel_q   <= pwdata[KSEL_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[IMG_W_W-1:0];
        REG_HEIGHT: height_q <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KSEL:   prdata = APB_DW'(ksel_q);
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // effective sizes
  logic [KSEL_W-1:0]  sel_eff;
  logic [KW-1:0]      ksize;
  logic [KW-1:0]      khalf;
  logic [CMPW-1:0]    weff;
  logic [IMG_H_W-1:0] heff;

  always_comb begin
    sel_eff = (ksel_q > 2'd2) ? 2'd2 : ksel_q;
    ksize   = KW'({sel_eff, 1'b0}) + KW'(3);
    if (ksize > KW'(KMAX)) ksize = KW'(KMAX);
    khalf   = ksize >> 1;
    if (width_q == '0) weff = CMPW'(1);
    else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) weff = CMPW'(MAX_WIDTH);
    else weff = CMPW'(width_q);
    if (height_q == '0) heff = IMG_H_W'(1);
    else if (height_q > IMG_H_W'(MAX_HEIGHT)) heff = IMG_H_W'(MAX_HEIGHT);
    else heff = height_q;
  end

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic rdy_o, rdy4, rdy3, rdy2;
  logic in_acc, s1_move;

  assign rdy_o      = !ov_q || out_ready_i;
  assign rdy4       = !v4_q || rdy_o;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = !v1_q || rdy2;
  assign in_acc     = in_valid_i && in_ready_o;
  assign s1_move    = v1_q && rdy2;

  // ---------------- position counters ----------------
  logic [CW-1:0]    col_q, c_cur;
  logic [ROW_W-1:0] row_q, r_cur;

  always_comb begin
    c_cur = (CMPW'(col_q) >= weff) ? '0 : col_q;
    r_cur = (IMG_H_W'(row_q) >= heff) ? '0 : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (CMPW'(c_cur) + CMPW'(1) >= weff) begin
        col_q <= '0;
        row_q <= (IMG_H_W'(r_cur) + IMG_H_W'(1) >= heff) ? '0 : r_cur + ROW_W'(1);
      end else begin
        col_q <= c_cur + CW'(1);
      end
    end
  end

  // ---------------- line store (read-modify-write) ----------------
  logic [LW-1:0]      line_mem [MAX_WIDTH];
  logic [LW-1:0]      ram_q;
  logic [LW-1:0]      wr_data_q;
  logic [LW-1:0]      col_word;
  logic [LW-1:0]      wr_word;
  logic [PIX_W-1:0]   s1_pix_q;
  logic [CW-1:0]      s1_c_q;
  logic [ROW_W-1:0]   s1_r_q;
  logic               s1_fwd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) ram_q <= line_mem[c_cur];
    if (s1_move) begin
      line_mem[s1_c_q] <= wr_word;
      wr_data_q        <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q     <= in_valid_i;
      // the item leaving stage 1 writes the same column this request reads
      s1_fwd_q <= in_valid_i && v1_q && (s1_c_q == c_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= pixel_i;
      s1_c_q   <= c_cur;
      s1_r_q   <= r_cur;
    end
  end

  assign col_word = s1_fwd_q ? wr_data_q : ram_q;
  assign wr_word  = {s1_pix_q, col_word[LW-1:PIX_W]};

  // ---------------- window ----------------
  logic [PIX_W-1:0] win_q [M][M];
  logic [PIX_W-1:0] win_d [M][M];
  logic [PIX_W-1:0] win2_q [M][M];
  logic             emit;
  meta_t            s1_meta;
  meta_t            m2_q, m3_q, m4_q;

  always_comb begin
    for (int i = 0; i < M; i++) begin
      for (int j = 0; j < M - 1; j++) win_d[i][j] = win_q[i][j+1];
      if (i < M - 1) win_d[i][M-1] = col_word[i*PIX_W +: PIX_W];
      else           win_d[i][M-1] = s1_pix_q;
    end
    emit         = (IMG_H_W'(s1_r_q) + IMG_H_W'(1) >= IMG_H_W'(ksize)) &&
                   (CMPW'(s1_c_q) + CMPW'(1) >= CMPW'(ksize));
    s1_meta.row  = s1_r_q - ROW_W'(khalf);
    s1_meta.col  = s1_c_q - CW'(khalf);
    s1_meta.last = (IMG_H_W'(s1_r_q) + IMG_H_W'(1) == heff) &&
                   (CMPW'(s1_c_q) + CMPW'(1) == weff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < M; i++)
        for (int j = 0; j < M; j++) win_q[i][j] <= '0;
    end else if (s1_move) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (rdy2) v2_q <= s1_move && emit;
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && emit && rdy2) begin
      win2_q <= win_d;
      m2_q   <= s1_meta;
    end
  end

  // ---------------- coefficients per tap ----------------
  logic [CFW-1:0] coef_tap [M][M];

  for (genvar gi = 0; gi < M; gi++) begin : g_row
    for (genvar gj = 0; gj < M; gj++) begin : g_col
      logic [CFW-1:0] coef_by_sel [3];
      for (genvar gs = 0; gs < 3; gs++) begin : g_sel
        localparam int KK = (2 * gs + 3 > KMAX) ? KMAX : 2 * gs + 3;
        localparam int HH = (KK - 1) / 2;
        localparam int TT = (KK - 3) / 2;
        localparam int CI = M - 1 - HH;
        localparam int AA = (gi > CI) ? gi - CI : CI - gi;
        localparam int BB = (gj > CI) ? gj - CI : CI - gj;
        localparam bit IN = (gi >= M - KK) && (gj >= M - KK);
        localparam logic [31:0] CV =
          IN ? coef_calc(TT, AA % 4, BB % 4, COEF_FRAC_BITS) : 32'd0;
        assign coef_by_sel[gs] = CV[CFW-1:0];
      end
      assign coef_tap[gi][gj] = coef_by_sel[sel_eff];
    end
  end

  // ---------------- multiply, row sums, total ----------------
  logic [PW-1:0]  prod_q [M][M];
  logic [RSW-1:0] rsum_q [M];
  logic [RSW-1:0] rsum_d [M];
  logic [TSW-1:0] total;
  logic [TSW-1:0] shifted;
  logic [PIX_W-1:0] value_q;
  meta_t          mo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy_o) ov_q <= v4_q;
    end
  end

  // taps outside the kernel may carry line data never written since reset
  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      for (int i = 0; i < M; i++)
        for (int j = 0; j < M; j++)
          prod_q[i][j] <= (coef_tap[i][j] == '0) ? '0 :
                          PW'(win2_q[i][j]) * PW'(coef_tap[i][j]);
      m3_q <= m2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < M; i++) begin
      rsum_d[i] = '0;
      for (int j = 0; j < M; j++) rsum_d[i] = rsum_d[i] + RSW'(prod_q[i][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      rsum_q <= rsum_d;
      m4_q   <= m3_q;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < M; i++) total = total + TSW'(rsum_q[i]);
    shifted = total >> COEF_FRAC_BITS;
  end

  always_ff @(posedge clk_i) begin
    if (v4_q && rdy_o) begin
      value_q <= (shifted > TSW'(255)) ? 8'd255 : shifted[PIX_W-1:0];
      mo_q    <= m4_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign value_o         = value_q;
  assign out_row_o       = mo_q.row;
  assign out_col_o       = mo_q.col;
  assign last_of_frame_o = mo_q.last;

  // ---------------- checks ----------------
  `GWF_ASSERT_IMP(a_fwd_has_item, clk_i, rst_ni, s1_fwd_q, v1_q)
  `GWF_ASSERT_NEXT(a_emit_reaches_mac, clk_i, rst_ni, s1_move && emit, v2_q)
  `GWF_ASSERT_NEXT(a_sum_reaches_out, clk_i, rst_ni, v4_q && rdy_o, out_valid_o)

endmodule
